### hw/rtl/u8bh_pkg.sv
// Shared types, constants and byte classification functions for the UTF-8 holdback block.
package u8bh_pkg;

    // Command codes carried on the command input.
    localparam logic CMD_DATA = 1'b0;
    localparam logic CMD_END  = 1'b1;

    // Number of sequence bytes that can be held, and the largest release packet.
    localparam int HELD_DEPTH = 3;
    localparam int PKT_BYTES  = 4;

    // Default depth of the queue between the front and back parts.
    localparam int QUEUE_DEPTH_DEF = 4;

    // Byte classification masks and patterns.
    localparam logic [7:0] ASCII_MASK = 8'h80;
    localparam logic [7:0] LEAD2_MASK = 8'hE0;
    localparam logic [7:0] LEAD2_PAT  = 8'hC0;
    localparam logic [7:0] LEAD3_MASK = 8'hF0;
    localparam logic [7:0] LEAD3_PAT  = 8'hE0;
    localparam logic [7:0] LEAD4_MASK = 8'hF8;
    localparam logic [7:0] LEAD4_PAT  = 8'hF0;
    localparam logic [7:0] CONT_MASK  = 8'hC0;
    localparam logic [7:0] CONT_PAT   = 8'h80;

    // One release packet: the bytes one input word lets go, in stream order.
    typedef struct packed {
        logic [PKT_BYTES-1:0][7:0] bytes;
        logic [2:0]                count;
    } pkt_t;

    // Sequence length announced by a byte; anything that does not open a
    // multi-byte sequence counts as length one.
    function automatic logic [2:0] seq_len(input logic [7:0] b);
        logic [2:0] len;
        begin
            if ((b & ASCII_MASK) == 8'h00)
                len = 3'd1;
            else if ((b & LEAD2_MASK) == LEAD2_PAT)
                len = 3'd2;
            else if ((b & LEAD3_MASK) == LEAD3_PAT)
                len = 3'd3;
            else if ((b & LEAD4_MASK) == LEAD4_PAT)
                len = 3'd4;
            else
                len = 3'd1;
            return len;
        end
    endfunction

    function automatic logic is_cont(input logic [7:0] b);
        return (b & CONT_MASK) == CONT_PAT;
    endfunction

endpackage

### hw/rtl/u8bh_front.sv
// Front part: accepts words, tracks the held sequence and builds release packets.
module u8bh_front
    import u8bh_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       command,
    input  logic [7:0] data_byte,
    input  logic       q_full,
    output logic       q_push,
    output pkt_t       q_pkt
);

    logic [HELD_DEPTH-1:0][7:0] held_reg;
    logic [HELD_DEPTH-1:0][7:0] held_next;
    logic [1:0]                 held_count_reg;
    logic [1:0]                 held_count_next;
    logic [2:0]                 exp_len_reg;
    logic [2:0]                 exp_len_next;

    logic       accept;
    logic       append;
    logic       release_held;
    logic [2:0] len;
    logic       cont;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;
    assign len      = seq_len(data_byte);
    assign cont     = is_cont(data_byte);

    always_comb
    begin
        held_next       = held_reg;
        held_count_next = held_count_reg;
        exp_len_next    = exp_len_reg;
        append          = 1'b0;
        release_held    = 1'b0;
        if (command == CMD_END)
        begin
            release_held = 1'b1;
        end
        else if (held_count_reg != 2'd0 && cont)
        begin
            if ({1'b0, held_count_reg} + 3'd1 >= exp_len_reg)
            begin
                release_held = 1'b1;
                append       = 1'b1;
            end
            else
            begin
                for (int i = 0; i < HELD_DEPTH; i++)
                begin
                    if (held_count_reg == 2'(i))
                        held_next[i] = data_byte;
                end
                held_count_next = held_count_reg + 2'd1;
            end
        end
        else
        begin
            release_held = 1'b1;
            if (len == 3'd1)
            begin
                append = 1'b1;
            end
            else
            begin
                held_next[0] = data_byte;
            end
        end

        if (release_held)
        begin
            // A new lead replaces the released sequence; otherwise nothing stays held.
            if (command != CMD_END && !append)
            begin
                held_count_next = 2'd1;
                exp_len_next    = len;
            end
            else
            begin
                held_count_next = 2'd0;
                exp_len_next    = 3'd0;
            end
        end
    end

    // Packet layout: held bytes first, then the current byte right behind them.
    always_comb
    begin
        for (int i = 0; i < HELD_DEPTH; i++)
        begin
            if (2'(i) < held_count_reg)
                q_pkt.bytes[i] = held_reg[i];
            else
                q_pkt.bytes[i] = data_byte;
        end
        q_pkt.bytes[PKT_BYTES-1] = data_byte;
        if (release_held)
            q_pkt.count = {1'b0, held_count_reg} + {2'b00, append};
        else
            q_pkt.count = 3'd0;
    end

    assign q_push = accept && (q_pkt.count != 3'd0);

    always_ff @(posedge clk)
    begin
        if (accept)
            held_reg <= held_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_count_reg <= 2'd0;
            exp_len_reg    <= 3'd0;
        end
        else if (accept)
        begin
            held_count_reg <= held_count_next;
            exp_len_reg    <= exp_len_next;
        end
    end

    // A held sequence is always still short of its announced length.
    a_held_short: assert property (@(posedge clk) disable iff (!rst_n)
        held_count_reg != 2'd0 |-> ({1'b0, held_count_reg} < exp_len_reg
                                    && exp_len_reg >= 3'd2))
        else $error("held count not below expected length");

    // With nothing held there is no expected length left over.
    a_idle_clear: assert property (@(posedge clk) disable iff (!rst_n)
        held_count_reg == 2'd0 |-> exp_len_reg == 3'd0)
        else $error("expected length set with nothing held");

endmodule

### hw/rtl/u8bh_queue.sv
// Short queue of release packets between the front and back parts.
module u8bh_queue
    import u8bh_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  pkt_t push_pkt,
    input  logic pop,
    output pkt_t head,
    output logic full,
    output logic empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    pkt_t             mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;

    assign full  = (cnt_reg == CNT_W'(DEPTH));
    assign empty = (cnt_reg == '0);
    assign head  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            cnt_next = cnt_reg + 1'b1;
        else if (pop && !push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_pkt;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Occupancy grows by one on each push that comes without a pop.
    a_cnt_track: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> cnt_reg == $past(cnt_reg) + 1'b1)
        else $error("queue occupancy did not grow on push");

endmodule

### hw/rtl/u8bh_back.sv
// Back part: serializes queued release packets into the registered output.
module u8bh_back
    import u8bh_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  pkt_t       head,
    input  logic       empty,
    output logic       pop,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       last
);

    logic [1:0] idx_reg;
    logic [1:0] idx_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic [7:0] out_byte_reg;
    logic       last_reg;
    logic       load;
    logic       is_end;

    assign load   = !empty && (!out_valid_reg || out_ready);
    assign is_end = ({1'b0, idx_reg} + 3'd1 == head.count);
    assign pop    = load && is_end;

    always_comb
    begin
        idx_next = idx_reg;
        if (load)
            idx_next = is_end ? 2'd0 : idx_reg + 2'd1;
        if (load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_byte_reg <= head.bytes[idx_reg];
            last_reg     <= is_end;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign last      = last_reg;

    // A queued packet always carries one to four bytes, and the read index stays inside it.
    a_pkt_count: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (head.count != 3'd0 && head.count <= 3'd4
                    && {1'b0, idx_reg} < head.count))
        else $error("bad packet count or index at queue head");

endmodule

### hw/rtl/utf8_boundary_holdback.sv
// Top level of the UTF-8 boundary holdback block.
// Usage:
//   The input channel (in_valid/in_ready) takes one word per handshake: a
//   command bit and a data byte. A data word either passes its byte straight
//   through, or holds it back as part of an unfinished UTF-8 sequence. An end
//   word flushes whatever is held. The output channel (out_valid/out_ready)
//   gives one byte per word, in stream order; last marks the final byte that a
//   given input word released. Words that release nothing produce no output.
//   The packet a word releases is written into the queue as the word is
//   accepted, and from there its first byte is loaded into the output
//   register; its other bytes follow one per cycle while out_ready is high.
//   Throughput: the front takes one input word per cycle while the
//   packet queue has room; the back gives one output byte per cycle while
//   out_ready is high. One input word may release up to four bytes, so
//   sustained input rate follows the average number of bytes released per
//   word, with the queue of QUEUE_DEPTH packets absorbing bursts.
//   When the receiver stalls, the output register holds its word, the queue
//   fills, and in_ready drops only once the queue is full.
//   Reset empties the queue and the output register and forgets any held
//   sequence; the held bytes themselves are not cleared.
module utf8_boundary_holdback
    import u8bh_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       command,
    input  logic [7:0] data_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       last
);

    pkt_t push_pkt;
    pkt_t head;
    logic push;
    logic pop;
    logic full;
    logic empty;

    // Front: classifies each byte and decides what is released now.
    u8bh_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .command   (command),
        .data_byte (data_byte),
        .q_full    (full),
        .q_push    (push),
        .q_pkt     (push_pkt)
    );

    // Queue: decouples the front from output stalls.
    u8bh_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_pkt (push_pkt),
        .pop      (pop),
        .head     (head),
        .full     (full),
        .empty    (empty)
    );

    // Back: unpacks each packet into the output register, one byte per cycle while out_ready is high.
    u8bh_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .empty     (empty),
        .pop       (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_byte  (out_byte),
        .last      (last)
    );

endmodule
